>>> rtl/core/scanner_frame_receiver_controller_macros.svh
// Assertion macros shared by the scanner frame receiver controller.
// Included by the top level; relies on i_clk and i_rst_n in scope.
`ifndef SCANNER_FRAME_RECEIVER_CONTROLLER_MACROS_SVH
`define SCANNER_FRAME_RECEIVER_CONTROLLER_MACROS_SVH

// Condition implies consequence in the same cycle.
`define SFRC_ASSERT_IMP(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Condition implies consequence in the next cycle.
`define SFRC_ASSERT_NXT(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/sfrc_pkg.sv
// Shared types and codes of the scanner frame receiver controller.
// No dependencies; used by every module of the block.
`default_nettype none
package sfrc_pkg;

    localparam logic [2:0] CMD_RX     = 3'd0;
    localparam logic [2:0] CMD_TICK   = 3'd1;
    localparam logic [2:0] CMD_START  = 3'd2;
    localparam logic [2:0] CMD_SENT   = 3'd3;
    localparam logic [2:0] CMD_DEACT  = 3'd4;

    localparam logic [2:0] REG_FRAME_IDLE  = 3'd0;
    localparam logic [2:0] REG_TRIM        = 3'd1;
    localparam logic [2:0] REG_ACT_MODE    = 3'd2;
    localparam logic [2:0] REG_SW_HIGH     = 3'd3;
    localparam logic [2:0] REG_SCAN_TO     = 3'd4;
    localparam logic [2:0] REG_ACT_WIN     = 3'd5;
    localparam logic [2:0] REG_CMD_WIN     = 3'd6;
    localparam logic [2:0] REG_TERM        = 3'd7;

    localparam logic [3:0] EV_NONE      = 4'd0;
    localparam logic [3:0] EV_ACTIVATED = 4'd1;
    localparam logic [3:0] EV_DEACT     = 4'd2;
    localparam logic [3:0] EV_ACT_RESP  = 4'd3;
    localparam logic [3:0] EV_CMD_RESP  = 4'd4;
    localparam logic [3:0] EV_CODE      = 4'd5;
    localparam logic [3:0] EV_UNEXP     = 4'd6;
    localparam logic [3:0] EV_OVERFLOW  = 4'd7;
    localparam logic [3:0] EV_CMD_TO    = 4'd8;
    localparam logic [3:0] EV_SCAN_TO   = 4'd9;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_ACT  = 2'd1;
    localparam logic [1:0] MODE_CMD  = 2'd2;
    localparam logic [1:0] MODE_CODE = 2'd3;

    localparam logic [1:0] AM_CMD  = 2'd0;
    localparam logic [1:0] AM_SW   = 2'd1;
    localparam logic [1:0] AM_BOTH = 2'd2;

    localparam logic [1:0] TX_ACTIVATE   = 2'b01;
    localparam logic [1:0] TX_DEACTIVATE = 2'b10;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;

    typedef enum logic [2:0] {
        K_DATA, K_TERM, K_TICK, K_START, K_SENT, K_DEACT, K_NOP
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] now;
        logic [7:0]  rx;
        logic [31:0] win;
    } t_item;

    typedef struct packed {
        logic [15:0] frame_idle;
        logic        trim;
        logic [1:0]  act_mode;
        logic        sw_high;
        logic [31:0] scan_to;
        logic [15:0] act_win;
        logic [15:0] cmd_win;
        logic [15:0] term;
    } t_cfg;

endpackage
`default_nettype wire

>>> rtl/core/sfrc_front.sv
// Front end: accepts input items, classifies them and resolves default windows.
// Depends on sfrc_pkg; feeds sfrc_queue.
`default_nettype none
module sfrc_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire sfrc_pkg::t_cfg  i_cfg,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire logic [2:0]      i_cmd,
    input  wire logic [31:0]     i_now_ms,
    input  wire logic [7:0]      i_rx_byte,
    input  wire logic [31:0]     i_window_ms,
    input  wire logic            i_q_full,
    output logic                 o_push,
    output sfrc_pkg::t_item      o_item
);

    logic            r_valid;
    sfrc_pkg::t_item r_item;
    sfrc_pkg::t_item n_item;
    logic            accept;
    logic            is_term;
    logic [7:0]      t_first;
    logic [7:0]      t_second;

    assign t_first  = i_cfg.term[15:8];
    assign t_second = i_cfg.term[7:0];
    assign is_term  = (t_first != 8'd0) &&
                      ((i_rx_byte == t_first) || ((t_second != 8'd0) && (i_rx_byte == t_second)));

    always_comb begin
        n_item.now = i_now_ms;
        n_item.rx  = i_rx_byte;
        n_item.win = i_window_ms;
        unique case (i_cmd)
            sfrc_pkg::CMD_RX:    n_item.kind = is_term ? sfrc_pkg::K_TERM : sfrc_pkg::K_DATA;
            sfrc_pkg::CMD_TICK:  n_item.kind = sfrc_pkg::K_TICK;
            sfrc_pkg::CMD_START: begin
                n_item.kind = sfrc_pkg::K_START;
                if (i_window_ms == 32'd0) n_item.win = i_cfg.scan_to;
            end
            sfrc_pkg::CMD_SENT:  begin
                n_item.kind = sfrc_pkg::K_SENT;
                if (i_window_ms == 32'd0) n_item.win = {16'd0, i_cfg.cmd_win};
            end
            sfrc_pkg::CMD_DEACT: n_item.kind = sfrc_pkg::K_DEACT;
            default:             n_item.kind = sfrc_pkg::K_NOP;
        endcase
    end

    assign o_in_stall = r_valid && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_q_full;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept || (r_valid && i_q_full);
        end
        if (accept) r_item <= n_item;
    end

endmodule
`default_nettype wire

>>> rtl/core/sfrc_queue.sv
// Short item queue between the front end and the back end.
// Depends on sfrc_pkg for the item type.
`default_nettype none
module sfrc_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire sfrc_pkg::t_item i_item,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output sfrc_pkg::t_item      o_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sfrc_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (do_pop)  r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            if (do_push && !do_pop)      r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
        if (do_push) r_mem[r_wr] <= i_item;
    end

endmodule
`default_nettype wire

>>> rtl/core/sfrc_back.sv
// Back end: executes items, holds scan state and frame store, emits results.
// Depends on sfrc_pkg; fed by sfrc_queue.
`default_nettype none
module sfrc_back #(
    parameter int MAX_FRAME = 64
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire sfrc_pkg::t_cfg  i_cfg,
    input  wire logic            i_empty,
    input  wire sfrc_pkg::t_item i_item,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output logic [3:0]           o_event_res,
    output logic [7:0]           o_frame_byte,
    output logic [6:0]           o_frame_length,
    output logic                 o_last,
    output logic                 o_switch_level,
    output logic [1:0]           o_tx_request,
    output logic [1:0]           o_scan_state,
    output logic                 o_scan_active
);

    localparam int AW = $clog2(MAX_FRAME);
    localparam int CW = $clog2(MAX_FRAME + 1);

    typedef enum logic [1:0] {S_IDLE, S_EVENT, S_READ, S_BYTE} t_state;

    t_state        r_state;
    logic [1:0]    r_mode,   n_mode;
    logic          r_active, n_active;
    logic [31:0]   r_sdl,    n_sdl;
    logic [31:0]   r_rdl,    n_rdl;
    logic [31:0]   r_last_t, n_last_t;
    logic [CW-1:0] r_count,  n_count;
    logic          r_sw,     n_sw;
    logic [AW-1:0] r_first,  n_first;
    logic [AW-1:0] r_lastnb, n_lastnb;
    logic          r_any,    n_any;

    logic [3:0]    r_ev,     n_ev;
    logic          n_frame;
    logic [AW-1:0] r_addr,   n_start;
    logic [CW-1:0] r_remain, r_len, n_len;
    logic [1:0]    r_tx,     n_tx;
    logic [1:0]    r_st_mode;
    logic          r_st_active, r_st_sw;

    logic [7:0]    r_mem [MAX_FRAME];
    logic [7:0]    r_rd_data;
    logic          we;

    logic          out_free;
    logic          emit;
    logic          start_item;
    logic          any_eff;
    logic          blank;
    logic          do_end;
    logic          do_finish;
    logic          due_resp;
    logic          due_scan;
    logic [31:0]   gap;
    logic [1:0]    tick_mode;
    logic          sw_drive;
    logic [CW-1:0] trim_len;

    assign out_free   = !o_out_valid || !i_out_stall;
    assign emit       = ((r_state == S_EVENT) || (r_state == S_BYTE)) && out_free;
    assign start_item = (r_state == S_IDLE) && !i_empty;
    assign o_pop      = start_item;
    assign any_eff    = (r_count != '0) && r_any;
    assign blank      = (i_item.rx == sfrc_pkg::CHAR_SPACE) || (i_item.rx == sfrc_pkg::CHAR_TAB);
    assign due_resp   = ((i_item.now - r_rdl) < 32'h8000_0000);
    assign due_scan   = ((i_item.now - r_sdl) < 32'h8000_0000);
    assign gap        = i_item.now - r_last_t;
    assign sw_drive   = (i_cfg.act_mode == sfrc_pkg::AM_SW) || (i_cfg.act_mode == sfrc_pkg::AM_BOTH);
    assign trim_len   = any_eff ? CW'(r_lastnb - r_first) + 1'b1 : '0;
    assign we         = start_item && (i_item.kind == sfrc_pkg::K_DATA) &&
                        (r_count < CW'(MAX_FRAME));

    always_comb begin
        n_mode = r_mode;  n_active = r_active; n_sdl = r_sdl; n_rdl = r_rdl;
        n_last_t = r_last_t; n_count = r_count; n_sw = r_sw;
        n_first = r_first; n_lastnb = r_lastnb; n_any = any_eff;
        n_ev = sfrc_pkg::EV_NONE; n_frame = 1'b0; n_start = '0; n_len = '0;
        n_tx = 2'b00; do_end = 1'b0; do_finish = 1'b0;
        tick_mode = r_mode;
        unique case (i_item.kind)
            sfrc_pkg::K_DATA: begin
                n_last_t = i_item.now;
                if (r_count >= CW'(MAX_FRAME)) begin
                    n_count = '0;
                    n_ev    = sfrc_pkg::EV_OVERFLOW;
                end else begin
                    n_count = r_count + 1'b1;
                    if (!blank) begin
                        if (!any_eff) n_first = r_count[AW-1:0];
                        n_lastnb = r_count[AW-1:0];
                        n_any    = 1'b1;
                    end
                end
            end
            sfrc_pkg::K_TERM: begin
                n_last_t = i_item.now;
                if (r_count != '0) do_finish = 1'b1;
            end
            sfrc_pkg::K_TICK: begin
                if ((r_count != '0) && (i_cfg.frame_idle != 16'd0) && !gap[31] &&
                    (gap >= {16'd0, i_cfg.frame_idle})) begin
                    do_finish = 1'b1;
                end else begin
                    if ((r_mode == sfrc_pkg::MODE_ACT) && due_resp) tick_mode = sfrc_pkg::MODE_CODE;
                    n_mode = tick_mode;
                    if ((tick_mode == sfrc_pkg::MODE_CMD) && due_resp) begin
                        n_mode = r_active ? sfrc_pkg::MODE_CODE : sfrc_pkg::MODE_IDLE;
                        n_ev   = sfrc_pkg::EV_CMD_TO;
                    end else if (r_active && (r_sdl != 32'd0) && due_scan) begin
                        do_end = 1'b1;
                        n_ev   = sfrc_pkg::EV_SCAN_TO;
                    end
                end
            end
            sfrc_pkg::K_START: begin
                if (r_active) n_tx = sfrc_pkg::TX_DEACTIVATE;
                n_count  = '0;
                n_last_t = 32'd0;
                if (sw_drive) n_sw = i_cfg.sw_high;
                if ((i_cfg.act_mode == sfrc_pkg::AM_CMD) || (i_cfg.act_mode == sfrc_pkg::AM_BOTH))
                    n_tx = n_tx | sfrc_pkg::TX_ACTIVATE;
                n_active = 1'b1;
                n_sdl    = (i_item.win == 32'd0) ? 32'd0 : i_item.now + i_item.win;
                n_rdl    = i_item.now + {16'd0, i_cfg.act_win};
                n_mode   = (i_cfg.act_win == 16'd0) ? sfrc_pkg::MODE_CODE : sfrc_pkg::MODE_ACT;
                n_ev     = sfrc_pkg::EV_ACTIVATED;
            end
            sfrc_pkg::K_SENT: begin
                n_count  = '0;
                n_last_t = 32'd0;
                n_rdl    = i_item.now + i_item.win;
                n_mode   = (i_item.win == 32'd0) ? sfrc_pkg::MODE_IDLE : sfrc_pkg::MODE_CMD;
            end
            sfrc_pkg::K_DEACT: begin
                do_end = 1'b1;
                n_ev   = sfrc_pkg::EV_DEACT;
            end
            default: ;
        endcase
        if (do_finish) begin
            n_count = '0;
            n_len   = i_cfg.trim ? trim_len : r_count;
            n_start = i_cfg.trim ? r_first : '0;
            if (n_len != '0) begin
                n_frame = 1'b1;
                case (r_mode)
                    sfrc_pkg::MODE_ACT:  n_ev = sfrc_pkg::EV_ACT_RESP;
                    sfrc_pkg::MODE_CMD:  n_ev = sfrc_pkg::EV_CMD_RESP;
                    sfrc_pkg::MODE_CODE: n_ev = sfrc_pkg::EV_CODE;
                    default:             n_ev = sfrc_pkg::EV_UNEXP;
                endcase
                if (r_mode == sfrc_pkg::MODE_CODE) do_end = 1'b1;
            end
        end
        if (do_end) begin
            n_tx     = n_tx | sfrc_pkg::TX_DEACTIVATE;
            if (sw_drive) n_sw = !i_cfg.sw_high;
            n_mode   = sfrc_pkg::MODE_IDLE;
            n_active = 1'b0;
            n_sdl    = 32'd0;
            n_rdl    = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[r_count[AW-1:0]] <= i_item.rx;
        if (r_state == S_READ) r_rd_data <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= sfrc_pkg::MODE_IDLE;
            r_active    <= 1'b0;
            r_sdl       <= 32'd0;
            r_rdl       <= 32'd0;
            r_last_t    <= 32'd0;
            r_count     <= '0;
            r_sw        <= 1'b0;
            r_any       <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall && !emit) o_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start_item) begin
                        r_mode <= n_mode; r_active <= n_active; r_sdl <= n_sdl;
                        r_rdl <= n_rdl; r_last_t <= n_last_t; r_count <= n_count;
                        r_sw <= n_sw; r_first <= n_first; r_lastnb <= n_lastnb;
                        r_any <= n_any;
                        r_ev <= n_ev; r_tx <= n_tx; r_addr <= n_start;
                        r_len <= n_len; r_remain <= n_len;
                        r_st_mode <= n_mode; r_st_active <= n_active; r_st_sw <= n_sw;
                        r_state <= n_frame ? S_READ : S_EVENT;
                    end
                end
                S_EVENT: begin
                    if (out_free) begin
                        o_out_valid    <= 1'b1;
                        o_event_res    <= r_ev;
                        o_frame_byte   <= 8'd0;
                        o_frame_length <= 7'd0;
                        o_last         <= 1'b1;
                        o_switch_level <= r_st_sw;
                        o_tx_request   <= r_tx;
                        o_scan_state   <= r_st_mode;
                        o_scan_active  <= r_st_active;
                        r_state        <= S_IDLE;
                    end
                end
                S_READ: r_state <= S_BYTE;
                S_BYTE: begin
                    if (out_free) begin
                        o_out_valid    <= 1'b1;
                        o_event_res    <= r_ev;
                        o_frame_byte   <= r_rd_data;
                        o_frame_length <= 7'(r_len);
                        o_last         <= (r_remain == CW'(1));
                        o_switch_level <= r_st_sw;
                        o_tx_request   <= r_tx;
                        o_scan_state   <= r_st_mode;
                        o_scan_active  <= r_st_active;
                        r_addr         <= r_addr + 1'b1;
                        r_remain       <= r_remain - 1'b1;
                        r_state        <= (r_remain == CW'(1)) ? S_IDLE : S_READ;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/scanner_frame_receiver_controller.sv
// Scanner frame receiver controller: link state, frame assembly and emission.
// A front end classifies each item and resolves default windows, a short queue
// decouples it from the back end, which holds all scan state and the frame
// store and emits the results. Every item gives at least one
// result; the back end takes an item from the queue only when idle, and a
// frame then gives one result per byte, each byte being read from the frame
// memory through its registered read port before it is presented. Any other
// item gives a single result. Input items keep arriving into the queue while
// results are being emitted or stalled, as long as the queue is not full.
// Configuration writes are always ready and take effect the next cycle.
`default_nettype none
`include "scanner_frame_receiver_controller_macros.svh"
module scanner_frame_receiver_controller #(
    parameter int MAX_FRAME   = 64,
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_cmd,
    input  wire logic [31:0] i_now_ms,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic [31:0] i_window_ms,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [3:0]       o_event_res,
    output logic [7:0]       o_frame_byte,
    output logic [6:0]       o_frame_length,
    output logic             o_last,
    output logic             o_switch_level,
    output logic [1:0]       o_tx_request,
    output logic [1:0]       o_scan_state,
    output logic             o_scan_active
);

    sfrc_pkg::t_cfg  r_cfg;
    sfrc_pkg::t_item f_item;
    sfrc_pkg::t_item q_item;
    logic            f_push;
    logic            q_full;
    logic            q_empty;
    logic            b_pop;
    logic            frame_ev;
    logic            idle_mode_ok;

    // The register port never waits.
    assign o_cfg_ready = 1'b1;

    // Result kinds that carry frame bytes, and the states allowed without a scan.
    assign frame_ev = (o_event_res == sfrc_pkg::EV_ACT_RESP) ||
                      (o_event_res == sfrc_pkg::EV_CMD_RESP) ||
                      (o_event_res == sfrc_pkg::EV_CODE) ||
                      (o_event_res == sfrc_pkg::EV_UNEXP);
    assign idle_mode_ok = (o_scan_state == sfrc_pkg::MODE_IDLE) ||
                          (o_scan_state == sfrc_pkg::MODE_CMD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_idle <= 16'd0;
            r_cfg.trim       <= 1'b0;
            r_cfg.act_mode   <= sfrc_pkg::AM_CMD;
            r_cfg.sw_high    <= 1'b1;
            r_cfg.scan_to    <= 32'd0;
            r_cfg.act_win    <= 16'd0;
            r_cfg.cmd_win    <= 16'd0;
            r_cfg.term       <= 16'h0D0A;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sfrc_pkg::REG_FRAME_IDLE: r_cfg.frame_idle <= i_cfg_data[15:0];
                sfrc_pkg::REG_TRIM:       r_cfg.trim       <= i_cfg_data[0];
                sfrc_pkg::REG_ACT_MODE:   r_cfg.act_mode   <= i_cfg_data[1:0];
                sfrc_pkg::REG_SW_HIGH:    r_cfg.sw_high    <= i_cfg_data[0];
                sfrc_pkg::REG_SCAN_TO:    r_cfg.scan_to    <= i_cfg_data;
                sfrc_pkg::REG_ACT_WIN:    r_cfg.act_win    <= i_cfg_data[15:0];
                sfrc_pkg::REG_CMD_WIN:    r_cfg.cmd_win    <= i_cfg_data[15:0];
                sfrc_pkg::REG_TERM:       r_cfg.term       <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    sfrc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_now_ms    (i_now_ms),
        .i_rx_byte   (i_rx_byte),
        .i_window_ms (i_window_ms),
        .i_q_full    (q_full),
        .o_push      (f_push),
        .o_item      (f_item)
    );

    sfrc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (b_pop),
        .o_empty (q_empty),
        .o_item  (q_item)
    );

    sfrc_back #(.MAX_FRAME(MAX_FRAME)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_empty        (q_empty),
        .i_item         (q_item),
        .o_pop          (b_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_event_res    (o_event_res),
        .o_frame_byte   (o_frame_byte),
        .o_frame_length (o_frame_length),
        .o_last         (o_last),
        .o_switch_level (o_switch_level),
        .o_tx_request   (o_tx_request),
        .o_scan_state   (o_scan_state),
        .o_scan_active  (o_scan_active)
    );

    // A frame result always carries a nonzero length.
    `SFRC_ASSERT_IMP(a_frame_len, o_out_valid && frame_ev, o_frame_length != 7'd0, "frame result with zero length")
    // A received code always ends the scan.
    `SFRC_ASSERT_IMP(a_code_ends, o_out_valid && (o_event_res == sfrc_pkg::EV_CODE), !o_scan_active && (o_scan_state == sfrc_pkg::MODE_IDLE), "code did not end scan")
    // Without a scan only idle or command wait is possible.
    `SFRC_ASSERT_IMP(a_idle_modes, o_out_valid && !o_scan_active, idle_mode_ok, "scan state without active scan")
    // A stalled result stays on the port.
    `SFRC_ASSERT_NXT(a_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_frame_byte) && $stable(o_last), "stalled result changed")

endmodule
`default_nettype wire
